[rtl/core/xbcj_pkg.sv]
// ============================================================================
// xbcj_pkg - shared types, constants and helpers for the x86 BCJ filter
// Beat group format passed from the front end to the back end, register
// indexes of the configuration port and the small arithmetic helpers.
// ============================================================================
package xbcj_pkg;

    localparam int WIN_LEN     = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef logic [7:0] t_byte;

    localparam t_byte OP_MASK = 8'hFE;
    localparam t_byte OP_CALL = 8'hE8;

    typedef enum logic [0:0] {
        CFG_ENCODE_MODE = 1'b0,
        CFG_START_POS   = 1'b1
    } t_cfg_idx;

    // One group of output beats produced by a single input beat.
    typedef struct packed {
        logic [WIN_LEN-1:0][7:0] bytes;  // index 0 = head byte
        logic [2:0]              cnt;    // number of beats, 1..5
        logic                    last;   // group ends the stream
        logic                    conv;   // displacement converted
        logic                    pass2;  // aged mask nonzero: second pass may apply
        logic [1:0]              sh_sel; // byte lane tested by second pass
        logic                    mode;   // 1 encode, 0 decode
        logic [31:0]             v1;     // displacement after first pass
        logic [31:0]             cur;    // position past the instruction
    } t_group;

    function automatic logic edge_byte(input t_byte b);
        return (b == 8'h00) || (b == 8'hFF);
    endfunction

    function automatic logic [31:0] apply_pos(input logic mode, input logic [31:0] v,
                                              input logic [31:0] cur);
        return mode ? (v + cur) : (v - cur);
    endfunction

    function automatic logic [31:0] xor_mask(input logic [1:0] sel);
        logic [31:0] m;
        unique case (sel)
            2'd0:    m = 32'h0000_00FF;
            2'd1:    m = 32'h0000_FFFF;
            2'd2:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

[rtl/core/xbcj_if.sv]
// ============================================================================
// xbcj_if - stream channels of the x86 BCJ filter
// Input and output byte channels, valid/ready handshake with a last marker.
// ============================================================================
interface xbcj_in_if;
    logic             valid;
    logic             ready;
    xbcj_pkg::t_byte  in_byte;
    logic             in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface xbcj_out_if;
    logic             valid;
    logic             ready;
    xbcj_pkg::t_byte  out_byte;
    logic             out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

[rtl/core/xbcj_front.sv]
// ============================================================================
// xbcj_front - window, opcode decision and first conversion pass
// Takes one input beat per cycle unless the queue is full, decides the head
// byte of a full window and emits one beat group per decision or stream end.
// ============================================================================
module xbcj_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  xbcj_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [31:0]            i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  xbcj_pkg::t_byte        i_in_byte,
    input  logic                   i_in_last,
    input  logic                   i_full,
    output logic                   o_push,
    output xbcj_pkg::t_group       o_group
);
    import xbcj_pkg::*;

    logic        r_mode,  n_mode;
    logic [31:0] r_start, n_start;
    logic [31:0] r_off,   n_off;
    logic [31:0] r_cur,   n_cur;
    logic [2:0]  r_fill,  n_fill;
    logic [2:0]  r_mask,  n_mask;
    logic [1:0]  r_skip,  n_skip;
    t_byte       r_win [4];
    t_byte       n_win [4];

    t_byte       w [WIN_LEN];
    logic        acc, win_full, is_op, reject, do_conv;
    logic [2:0]  m_aged, probe_idx;
    logic [31:0] v0;

    assign o_in_ready = !i_full;
    assign acc        = i_in_valid && !i_full;

    // window as it stands with the new byte placed at the fill point
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w[i] = (r_fill == 3'(i)) ? i_in_byte : r_win[i];
        end
        w[4] = i_in_byte;
    end

    assign win_full  = (r_fill == 3'd4);
    assign is_op     = ((w[0] & OP_MASK) == OP_CALL);
    assign m_aged    = (r_skip > 2'd2) ? 3'd0 : (r_mask >> r_skip);
    assign probe_idx = {1'b0, m_aged[2:1]} + 3'd1;
    assign reject    = (m_aged != 3'd0) &&
                       ((m_aged > 3'd4) || (m_aged == 3'd3) || edge_byte(w[probe_idx]));
    assign do_conv   = win_full && is_op && !reject && edge_byte(w[4]);
    assign v0        = {w[4], w[3], w[2], w[1]};

    always_comb begin
        for (int i = 0; i < WIN_LEN; i++) begin
            o_group.bytes[i] = w[i];
        end
        if (win_full) begin
            o_group.cnt = (do_conv || i_in_last) ? 3'd5 : 3'd1;
        end else begin
            o_group.cnt = r_fill + 3'd1;
        end
        o_group.last   = i_in_last;
        o_group.conv   = do_conv;
        o_group.pass2  = (m_aged != 3'd0);
        o_group.sh_sel = m_aged[2:1];
        o_group.mode   = r_mode;
        o_group.v1     = apply_pos(r_mode, v0, r_cur);
        o_group.cur    = r_cur;
    end

    assign o_push = acc && (win_full || i_in_last);

    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_off   = r_off;
        n_cur   = r_cur;
        n_fill  = r_fill;
        n_mask  = r_mask;
        n_skip  = r_skip;
        n_win   = r_win;
        if (acc) begin
            if (i_in_last) begin
                n_fill = 3'd0;
                n_mask = 3'd0;
                n_skip = 2'd0;
                n_off  = 32'd0;
                n_cur  = r_start + 32'd5;
            end else if (!win_full) begin
                for (int i = 0; i < 4; i++) begin
                    if (r_fill == 3'(i)) n_win[i] = i_in_byte;
                end
                n_fill = r_fill + 3'd1;
            end else if (do_conv) begin
                n_fill = 3'd0;
                n_mask = 3'd0;
                n_skip = 2'd0;
                n_off  = r_off + 32'd5;
                n_cur  = r_cur + 32'd5;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    n_win[i] = w[i+1];
                end
                n_fill = 3'd4;
                n_off  = r_off + 32'd1;
                n_cur  = r_cur + 32'd1;
                if (is_op) begin
                    n_mask = (m_aged >> 1) | 3'd4;
                    n_skip = 2'd0;
                end else begin
                    n_skip = (r_skip == 2'd3) ? r_skip : r_skip + 2'd1;
                end
            end
        end
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENCODE_MODE: n_mode = i_cfg_wdata[0];
                CFG_START_POS: begin
                    n_start = i_cfg_wdata;
                    n_cur   = i_cfg_wdata + 32'd5 + r_off;
                end
                default: n_mode = r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b1;
            r_start <= 32'd0;
            r_off   <= 32'd0;
            r_cur   <= 32'd5;
            r_fill  <= 3'd0;
            r_mask  <= 3'd0;
            r_skip  <= 2'd0;
        end else begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_off   <= n_off;
            r_cur   <= n_cur;
            r_fill  <= n_fill;
            r_mask  <= n_mask;
            r_skip  <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in_last) |=> (r_fill == 3'd0 && r_mask == 3'd0 &&
                                r_skip == 2'd0 && r_off == 32'd0))
        else $error("stream state not cleared after last beat");
    a_conv_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && do_conv) |=> (r_fill == 3'd0 && r_mask == 3'd0))
        else $error("window not emptied after conversion");
`endif

endmodule

[rtl/core/xbcj_queue.sv]
// ============================================================================
// xbcj_queue - short group queue between front and back end
// Four-entry FIFO of beat groups; push and pop may happen in the same cycle.
// ============================================================================
module xbcj_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  xbcj_pkg::t_group   i_group,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output xbcj_pkg::t_group   o_head
);
    import xbcj_pkg::*;

    t_group              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp, n_wp;
    logic [QPTR_W-1:0]   r_rp, n_rp;
    logic [QCNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp    = i_push ? r_wp + QPTR_W'(1) : r_wp;
        n_rp    = i_pop  ? r_rp + QPTR_W'(1) : r_rp;
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + QCNT_W'(1);
        if (!i_push && i_pop) n_count = r_count - QCNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_group;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("group queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("group queue underflow");
`endif

endmodule

[rtl/core/xbcj_back.sv]
// ============================================================================
// xbcj_back - second conversion pass and beat serializer
// Loads one group from the queue, finishes the displacement and sends its
// beats out one per cycle while the output is ready.
// ============================================================================
module xbcj_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  xbcj_pkg::t_group   i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output xbcj_pkg::t_byte    o_out_byte,
    output logic               o_out_last
);
    import xbcj_pkg::*;

    logic                     r_busy, n_busy;
    logic [WIN_LEN-1:0][7:0]  r_bytes, n_bytes;
    logic [2:0]               r_cnt, n_cnt;
    logic [2:0]               r_idx, n_idx;
    logic                     r_last, n_last;

    logic        beat_done, at_final, load, hit;
    t_byte       probe;
    logic [31:0] v2;

    assign beat_done = r_busy && i_out_ready;
    assign at_final  = (r_idx == r_cnt - 3'd1);
    assign load      = i_head_valid && (!r_busy || (beat_done && at_final));
    assign o_pop     = load;

    always_comb begin
        unique case (i_head.sh_sel)
            2'd0:    probe = i_head.v1[7:0];
            2'd1:    probe = i_head.v1[15:8];
            2'd2:    probe = i_head.v1[23:16];
            default: probe = i_head.v1[31:24];
        endcase
        hit = i_head.pass2 && edge_byte(probe);
        v2  = hit ? apply_pos(i_head.mode, i_head.v1 ^ xor_mask(i_head.sh_sel), i_head.cur)
                  : i_head.v1;
    end

    always_comb begin
        n_busy  = r_busy;
        n_bytes = r_bytes;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_last  = r_last;
        if (load) begin
            n_busy = 1'b1;
            n_idx  = 3'd0;
            n_cnt  = i_head.cnt;
            n_last = i_head.last;
            if (i_head.conv) begin
                n_bytes[0] = i_head.bytes[0];
                n_bytes[1] = v2[7:0];
                n_bytes[2] = v2[15:8];
                n_bytes[3] = v2[23:16];
                n_bytes[4] = {8{v2[24]}};
            end else begin
                n_bytes = i_head.bytes;
            end
        end else if (beat_done) begin
            if (at_final) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
            r_cnt  <= 3'd1;
            r_last <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_cnt  <= n_cnt;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

    assign o_out_valid = r_busy;
    assign o_out_byte  = r_bytes[r_idx];
    assign o_out_last  = r_last && at_final;

endmodule

[rtl/core/x86_branch_call_jump_filter_unit.sv]
// ============================================================================
// x86_branch_call_jump_filter_unit - streaming x86 BCJ converter
// Rewrites the displacements of near CALL/JMP opcodes between relative and
// absolute form on a byte stream, one byte beat in and one byte beat out.
// ============================================================================
// Usage:
//   i_in  : input byte beats (in_byte, in_last), valid/ready.
//   o_out : filtered byte beats (out_byte, out_last), valid/ready.
//   Config: i_cfg_we/i_cfg_idx/i_cfg_wdata, write-only; index 0 is the
//           encode mode (1 encode, 0 decode), index 1 the start position.
//           Write only while the stream is quiet.
//   Path: a beat that completes a decision passes the group queue and
//           the serializer registers before it shows up on o_out. Bytes
//           sit in the five-byte window until a decision or in_last frees them.
//   Throughput: one beat per cycle in and out when neither side stalls. A
//           converted instruction leaves as five beats while the next four
//           input beats only refill the window, so the four-group queue
//           absorbs the burst. A run of one-byte streams right after a
//           conversion fills it; i_in.ready then drops.
//   Stalls: when o_out.ready is low the serializer holds its beat; the
//           front keeps taking input until the group queue fills, then
//           drops i_in.ready.
//   Reset: synchronous, active low. Encode mode 1, start position 0,
//           window, mask, skip count and offset cleared, queue empty.
//           After every in_last beat the stream state clears the same way.
// ============================================================================
module x86_branch_call_jump_filter_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  xbcj_pkg::t_cfg_idx   i_cfg_idx,
    input  logic [31:0]          i_cfg_wdata,
    xbcj_in_if.sink              i_in,
    xbcj_out_if.source           o_out
);
    import xbcj_pkg::*;

    // front -> queue
    logic    push, q_full;
    t_group  push_group;

    // queue -> back
    logic    pop, q_valid;
    t_group  head_group;

    // Front: window, mask/skip tracking and first displacement pass.
    xbcj_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_in_byte   (i_in.in_byte),
        .i_in_last   (i_in.in_last),
        .i_full      (q_full),
        .o_push      (push),
        .o_group     (push_group)
    );

    // Short queue of beat groups decouples the two sides.
    xbcj_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (push_group),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head_group)
    );

    // Back: second pass on load, then one beat per cycle while o_out is ready.
    xbcj_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (head_group),
        .o_pop        (pop),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_byte   (o_out.out_byte),
        .o_out_last   (o_out.out_last)
    );

endmodule

[test/x86_branch_call_jump_filter_unit_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// x86_branch_call_jump_filter_unit_tb - self-checking bench for the BCJ filter
// Drives byte streams with last markers through the valid/ready channels,
// predicts every filtered beat with an independent CALL/JMP converter and
// checks each output beat in order. Directed streams cover short streams,
// conversion both ways, mask rejection and a register change mid-stream;
// random streams follow under several sender/receiver pacing phases.
// ============================================================================
module x86_branch_call_jump_filter_unit_tb;
    import xbcj_pkg::*;

    // One expected output beat.
    typedef struct {
        t_byte data;
        logic  last;
    } t_out_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [31:0] i_cfg_wdata;

    xbcj_in_if  in_ch ();
    xbcj_out_if out_ch ();

    x86_branch_call_jump_filter_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // ------------------------------------------------------------------------
    // Converter shadow state: registers and the stream state
    // ------------------------------------------------------------------------
    logic        enc_mode  = 1'b1;
    logic [31:0] start_pos = 32'd0;

    t_byte       win_q [WIN_LEN];
    int unsigned win_fill;
    logic [2:0]  prior_mask_q;
    logic [1:0]  skip_cnt;
    logic [31:0] strm_ofs;

    t_out_beat   filtered_beats_due [$];
    int unsigned mismatch_cnt;

    // Pacing, in percent of cycles.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // ------------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The 2 ms timeout lies far beyond the worst-case run of this bench.
    initial begin
        #2_000_000;
        $display("[x86_branch_call_jump_filter_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Converter
    // ------------------------------------------------------------------------
    function automatic logic is_rim_byte(input t_byte b);
        return (b == 8'h00) || (b == 8'hFF);
    endfunction

    function automatic logic [31:0] shift_by_pos(input logic [31:0] v,
                                                 input logic [31:0] cur);
        return enc_mode ? (v + cur) : (v - cur);
    endfunction

    function automatic void clear_stream();
        foreach (win_q[i]) win_q[i] = 8'h00;
        win_fill     = 0;
        prior_mask_q = 3'd0;
        skip_cnt     = 2'd0;
        strm_ofs     = 32'd0;
    endfunction

    function automatic void push_due(input t_byte b);
        t_out_beat beat;
        beat.data = b;
        beat.last = 1'b0;
        filtered_beats_due.push_back(beat);
    endfunction

    // Head byte leaves alone; window slides by one.
    function automatic void release_head();
        push_due(win_q[0]);
        for (int i = 0; i < WIN_LEN - 1; i++) win_q[i] = win_q[i+1];
        win_fill = WIN_LEN - 1;
        strm_ofs = strm_ofs + 32'd1;
    endfunction

    function automatic void decide_head();
        logic [2:0]  m;
        logic [31:0] disp;
        logic [31:0] cur;
        logic [31:0] lane;
        logic [4:0]  sh;

        if ((win_q[0] & OP_MASK) != OP_CALL) begin
            if (skip_cnt != 2'd3) skip_cnt = skip_cnt + 2'd1;
            release_head();
            return;
        end
        // age the mask by the bytes skipped since the last opcode
        m = prior_mask_q;
        if (skip_cnt > 2'd2) begin
            m = 3'd0;
        end else begin
            m = m >> skip_cnt;
            if (m != 3'd0 && (m > 3'd4 || m == 3'd3 || is_rim_byte(win_q[(m >> 1) + 1]))) begin
                skip_cnt     = 2'd0;
                prior_mask_q = (m >> 1) | 3'd4;
                release_head();
                return;
            end
        end
        skip_cnt = 2'd0;
        if (!is_rim_byte(win_q[4])) begin
            prior_mask_q = (m >> 1) | 3'd4;
            release_head();
            return;
        end
        disp = {win_q[4], win_q[3], win_q[2], win_q[1]};
        cur  = start_pos + 32'd5 + strm_ofs;
        disp = shift_by_pos(disp, cur);
        if (m != 3'd0) begin
            sh   = {m & 3'd6, 2'b00};
            lane = disp >> sh;
            if (is_rim_byte(lane[7:0])) begin
                disp = disp ^ ((32'h100 << sh) - 32'd1);
                disp = shift_by_pos(disp, cur);
            end
        end
        prior_mask_q = 3'd0;
        push_due(win_q[0]);
        push_due(disp[7:0]);
        push_due(disp[15:8]);
        push_due(disp[23:16]);
        push_due({8{disp[24]}});
        win_fill = 0;
        strm_ofs = strm_ofs + 32'd5;
    endfunction

    // Expected output beats for one accepted input beat.
    function automatic void predict_filtered_beats(input t_byte b, input logic l);
        int unsigned n_before;

        n_before = filtered_beats_due.size();
        if (win_fill >= WIN_LEN) win_fill = WIN_LEN - 1;
        win_q[win_fill] = b;
        win_fill++;
        if (win_fill == WIN_LEN) decide_head();
        if (l) begin
            // flush the window unchanged; last marker on the final beat
            for (int i = 0; i < win_fill; i++) push_due(win_q[i]);
            if (filtered_beats_due.size() > n_before)
                filtered_beats_due[filtered_beats_due.size()-1].last = 1'b1;
            clear_stream();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random stalls and the beat checker
    // ------------------------------------------------------------------------
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_beat due;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (filtered_beats_due.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got byte %02h last %0b",
                         $time, out_ch.out_byte, out_ch.out_last);
                mismatch_cnt++;
            end else begin
                due = filtered_beats_due.pop_front();
                if (due.data !== out_ch.out_byte || due.last !== out_ch.out_last) begin
                    $display("%0t: mismatch, expected byte %02h last %0b, got byte %02h last %0b",
                             $time, due.data, due.last, out_ch.out_byte, out_ch.out_last);
                    mismatch_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // One input beat; returns at the edge where it is taken.
    task automatic send_beat(input t_byte b, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= l;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_filtered_beats(b, l);
    endtask

    task automatic send_stream(input t_byte bytes [$]);
        foreach (bytes[i]) send_beat(bytes[i], i == bytes.size() - 1);
    endtask

    // Quiet the input, wait for every due beat, then let the pipe settle.
    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        while (filtered_beats_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_ENCODE_MODE: enc_mode  = val[0];
            CFG_START_POS:   start_pos = val;
            default: ;
        endcase
    endtask

    task automatic set_pace(input int unsigned idle_pct, input int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Random byte biased toward 00/FF so displacement tops hit often.
    function automatic t_byte any_byte();
        if ($urandom_range(99) < 15) return $urandom_range(1) ? 8'hFF : 8'h00;
        return t_byte'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Streams shorter than the window pass through untouched.
    task automatic test_short_streams();
        send_stream('{OP_CALL});
        send_stream('{8'hE9, 8'h00, 8'hFF, 8'hFF});
        drain_and_settle();
    endtask

    // CALL then JMP with 00 and FF tops, reset register values (encode, 0).
    task automatic test_call_jump_convert();
        send_stream('{OP_CALL, 8'h12, 8'h34, 8'h56, 8'h00,
                      8'hE9, 8'h78, 8'h9A, 8'hBC, 8'hFF});
        drain_and_settle();
    endtask

    // Three opcodes back to back: mask builds up and rejects the third.
    task automatic test_mask_reject();
        send_stream('{OP_CALL, OP_CALL, OP_CALL, 8'h41, 8'h42, 8'h43, 8'h44});
        drain_and_settle();
    endtask

    // Registers change while four bytes sit in the window; position wraps.
    task automatic test_midstream_config();
        send_beat(OP_CALL, 1'b0);
        send_beat(OP_CALL, 1'b0);
        send_beat(8'h12, 1'b0);
        send_beat(8'h34, 1'b0);
        drain_and_settle();
        set_reg(CFG_ENCODE_MODE, 32'd0);
        set_reg(CFG_START_POS, 32'hFFFF_FFF0);
        send_stream('{8'h56, 8'h00, 8'h00});
        drain_and_settle();
    endtask

    // Mostly well-formed CALL/JMP patterns with random content, some noise.
    task automatic run_random_traffic(input int unsigned n_beats);
        t_byte       b;
        int unsigned tail_len;

        tail_len = 0;
        for (int unsigned k = 0; k < n_beats; k++) begin
            if (tail_len == 0) begin
                if ($urandom_range(99) < 30) begin
                    b        = $urandom_range(1) ? 8'hE9 : OP_CALL;
                    tail_len = 4;
                end else begin
                    b = any_byte();
                end
            end else begin
                if (tail_len == 1 && $urandom_range(99) < 80)
                    b = $urandom_range(1) ? 8'hFF : 8'h00;
                else
                    b = any_byte();
                tail_len--;
            end
            send_beat(b, $urandom_range(99) < 3);
        end
    endtask

    task automatic test_random_phases();
        // no idling at all
        drain_and_settle();
        set_reg(CFG_ENCODE_MODE, 32'd1);
        set_reg(CFG_START_POS, 32'd0);
        set_pace(0, 0);
        run_random_traffic(30);

        // sparse sender
        drain_and_settle();
        set_reg(CFG_ENCODE_MODE, 32'd0);
        set_reg(CFG_START_POS, 32'hFFFF_FFFF);
        set_pace(87, 0);
        run_random_traffic(30);

        // heavy back-pressure
        drain_and_settle();
        set_reg(CFG_ENCODE_MODE, 32'd1);
        set_reg(CFG_START_POS, $urandom);
        set_pace(0, 87);
        run_random_traffic(30);

        // light gaps on both sides, ends with a flushing beat
        drain_and_settle();
        set_reg(CFG_ENCODE_MODE, 32'd0);
        set_reg(CFG_START_POS, $urandom);
        set_pace(18, 18);
        run_random_traffic(30);
        send_beat(any_byte(), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_ENCODE_MODE;
        i_cfg_wdata   = 32'd0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        mismatch_cnt  = 0;
        clear_stream();
        set_pace(0, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_streams();
        test_call_jump_convert();
        test_mask_reject();
        test_midstream_config();
        test_random_phases();

        drain_and_settle();
        if (mismatch_cnt == 0) begin
            $display("[x86_branch_call_jump_filter_unit] OK");
        end else begin
            $display("[x86_branch_call_jump_filter_unit] ERROR");
        end
        $finish;
    end

endmodule
